FILE: hw/rtl/fsc_pkg.sv
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types and constants for the frustum sphere cull block.
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int REG_COUNT   = 4;
  localparam int CFG_IDX_W   = 8;
  localparam int COL_W       = 64;
  localparam int COEF_W      = 32;
  localparam int CTR_W       = 24;
  localparam int RAD_W       = 23;
  localparam int ROWSUM_W    = 18;  // signed Q5.12 row sum
  localparam int MAG_W       = 17;  // magnitude of a row sum
  localparam int SUMSQ_W     = 34;  // a*a + b*b + c*c
  localparam int LEN_W       = 17;  // floor(sqrt(S))
  localparam int DVD_W       = 33;  // |v| << 16
  localparam int SQRT_STEPS  = 17;
  localparam int DIV_STEPS   = 33;

  localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_COL0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_COL1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_COL2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_COL3 = 8'd3;

  typedef struct packed {
    logic signed [COEF_W-1:0] nx;
    logic signed [COEF_W-1:0] ny;
    logic signed [COEF_W-1:0] nz;
    logic signed [COEF_W-1:0] d;
  } plane_t;

  typedef enum logic [2:0] {
    BLD_IDLE,
    BLD_SUMSQ,
    BLD_SQRT,
    BLD_DIV,
    BLD_NEXT
  } bld_state_t;

  typedef struct packed {
    logic start;
  } bld_ctrl_t;

  typedef struct packed {
    logic busy;
  } bld_stat_t;

endpackage

FILE: hw/rtl/frustum_sphere_cull_top.sv
// ----------------------------------------------------------------------------
// frustum_sphere_cull_top
// Sphere against view-frustum culling with planes taken from a projection
// matrix written through the configuration channel.
// ----------------------------------------------------------------------------
// The block takes one sphere per cycle while no rebuild runs and the result
// side is not stalled, and returns one visible flag per sphere, in order,
// through its input, product and result registers; a stalled result holds the
// pipeline while the earlier stages keep filling. After reset and after every
// write to a matrix column the six planes are rebuilt: each plane sums three
// squares, takes a bit-serial square root and divides its four coefficients
// bit by bit (a zero normal skips the divides). s_tready is low for the whole
// rebuild. The user must write columns only while no sphere is in flight; the
// block does not enforce this. A write to an index above 3 is ignored.
// ----------------------------------------------------------------------------
module frustum_sphere_cull_top (
  input  logic                          clk,
  input  logic                          rst,
  // slave stream: sphere
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [95:0]                   s_tdata,   // center_x, center_y, center_z, radius
  // master stream: result
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // visible
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fsc_pkg::COL_W-1:0]     cfg_data
);
  import fsc_pkg::*;

  logic [3:0][COL_W-1:0] matrix;
  bld_ctrl_t  bctrl;
  bld_stat_t  bstat;
  plane_t [PLANE_COUNT-1:0] planes;
  logic cfg_hit;
  logic visible;

  // Configuration always ready; a write to a column restarts the rebuild
  assign cfg_ready   = 1'b1;
  assign cfg_hit     = cfg_valid && (cfg_index < CFG_IDX_W'(REG_COUNT));
  assign bctrl.start = cfg_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix[0] <= 64'h0000_0000_0000_1000;
      matrix[1] <= 64'h0000_0000_1000_0000;
      matrix[2] <= 64'h0000_1000_0000_0000;
      matrix[3] <= 64'h1000_0000_0000_0000;
    end else if (cfg_hit) begin
      case (cfg_index)
        REG_MATRIX_COL0: matrix[0] <= cfg_data;
        REG_MATRIX_COL1: matrix[1] <= cfg_data;
        REG_MATRIX_COL2: matrix[2] <= cfg_data;
        REG_MATRIX_COL3: matrix[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  fsc_plane_builder u_builder (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (bctrl),
    .matrix (matrix),
    .stat   (bstat),
    .planes (planes)
  );

  fsc_sphere_test u_test (
    .clk       (clk),
    .rst       (rst),
    .planes    (planes),
    .enable    (!bstat.busy),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .cx_in     (signed'(s_tdata[23:0])),
    .cy_in     (signed'(s_tdata[47:24])),
    .cz_in     (signed'(s_tdata[71:48])),
    .r_in      (s_tdata[94:72]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .visible   (visible)
  );

  assign m_tdata = {7'b0, visible};

  // Reset kicks off a rebuild
  a_rst_build: assert property (@(posedge clk) rst |=> bstat.busy)
    else $error("rebuild not started by reset");

  // A column write starts a rebuild
  a_cfg_build: assert property (@(posedge clk) disable iff (rst) cfg_hit |=> bstat.busy)
    else $error("rebuild not started by column write");

  // No sphere is taken while the planes are being rebuilt
  a_no_accept: assert property (@(posedge clk) disable iff (rst) bstat.busy |-> !s_tready)
    else $error("sphere transfer during rebuild");

endmodule

FILE: hw/rtl/fsc_plane_builder.sv
// ----------------------------------------------------------------------------
// fsc_plane_builder
// Derives and normalises the six frustum planes, one bit per cycle through a
// shared square root and divider.
// ----------------------------------------------------------------------------
module fsc_plane_builder (
  input  logic                                  clk,
  input  logic                                  rst,
  input  fsc_pkg::bld_ctrl_t                    ctrl,
  input  logic [3:0][fsc_pkg::COL_W-1:0]        matrix,
  output fsc_pkg::bld_stat_t                    stat,
  output fsc_pkg::plane_t [fsc_pkg::PLANE_COUNT-1:0] planes
);
  import fsc_pkg::*;

  bld_state_t state, state_next;
  logic [2:0] plane_idx;
  logic [1:0] coef_idx;
  logic [5:0] cnt;

  logic [SUMSQ_W-1:0]  acc;
  logic [SUMSQ_W-1:0]  sq_src;
  logic [LEN_W+1:0]    sq_rem;
  logic [LEN_W-1:0]    root;
  logic [LEN_W-1:0]    len;
  logic [MAG_W-1:0]    dv_rem;
  logic [DVD_W-1:0]    dvd;
  logic                neg;

  logic signed [ROWSUM_W-1:0] vrow [4];
  logic [2*ROWSUM_W-1:0]      square;
  logic [SUMSQ_W-1:0]         acc_sum;

  // Row sums for the plane in hand: row 3 plus or minus row plane_idx/2
  always_comb begin
    logic [1:0] row;
    logic signed [ROWSUM_W-1:0] s3, sr;
    row = plane_idx[2:1];
    for (int j = 0; j < 4; j++) begin
      s3 = ROWSUM_W'(signed'(matrix[j][63:48]));
      sr = ROWSUM_W'(signed'(matrix[j][row*16 +: 16]));
      vrow[j] = plane_idx[0] ? (s3 + sr) : (s3 - sr);
    end
  end

  // Full-width signed product; a square is never negative
  assign square  = vrow[coef_idx] * vrow[coef_idx];
  assign acc_sum = acc + square[SUMSQ_W-1:0];

  // Square root step
  logic [LEN_W+1:0] sq_rem2, sq_trial, sq_rem_next;
  logic [LEN_W-1:0] root_next;
  always_comb begin
    sq_rem2  = {sq_rem[LEN_W-1:0], sq_src[SUMSQ_W-1 -: 2]};
    sq_trial = {root, 2'b01};
    if (sq_rem2 >= sq_trial) begin
      sq_rem_next = sq_rem2 - sq_trial;
      root_next   = {root[LEN_W-2:0], 1'b1};
    end else begin
      sq_rem_next = sq_rem2;
      root_next   = {root[LEN_W-2:0], 1'b0};
    end
  end

  // Divide step
  logic [MAG_W:0]     dv_r2, dv_diff;
  logic [MAG_W-1:0]   dv_rem_next;
  logic [DVD_W-1:0]   dvd_next;
  always_comb begin
    dv_r2   = {dv_rem, dvd[DVD_W-1]};
    dv_diff = dv_r2 - {1'b0, len};
    if (dv_r2 >= {1'b0, len}) begin
      dv_rem_next = dv_diff[MAG_W-1:0];
      dvd_next    = {dvd[DVD_W-2:0], 1'b1};
    end else begin
      dv_rem_next = dv_r2[MAG_W-1:0];
      dvd_next    = {dvd[DVD_W-2:0], 1'b0};
    end
  end

  // Signed, saturated coefficient from the finished quotient
  logic signed [COEF_W-1:0] coef;
  always_comb begin
    if (!neg) begin
      coef = (dvd_next > DVD_W'(COEF_MAX)) ? COEF_MAX : signed'(dvd_next[COEF_W-1:0]);
    end else begin
      coef = (dvd_next > {1'b0, COEF_MIN}) ? COEF_MIN : signed'(-dvd_next[COEF_W-1:0]);
    end
  end

  // Next coefficient to divide, magnitude and sign
  logic [1:0]              div_idx;
  logic signed [ROWSUM_W-1:0] div_v;
  logic [ROWSUM_W-1:0]     div_abs;
  assign div_idx = (state == BLD_SQRT) ? 2'd0 : coef_idx + 2'd1;
  assign div_v   = vrow[div_idx];
  assign div_abs = div_v[ROWSUM_W-1] ? unsigned'(-div_v) : unsigned'(div_v);

  always_comb begin
    state_next = state;
    unique case (state)
      BLD_IDLE:  state_next = BLD_IDLE;
      BLD_SUMSQ: if (coef_idx == 2'd2) state_next = BLD_SQRT;
      BLD_SQRT: begin
        if (cnt == 6'(SQRT_STEPS - 1)) state_next = (root_next == '0) ? BLD_NEXT : BLD_DIV;
      end
      BLD_DIV: begin
        if (cnt == 6'(DIV_STEPS - 1) && coef_idx == 2'd3) state_next = BLD_NEXT;
      end
      BLD_NEXT:  state_next = (plane_idx == 3'(PLANE_COUNT - 1)) ? BLD_IDLE : BLD_SUMSQ;
      default:   state_next = BLD_IDLE;
    endcase
    if (ctrl.start) state_next = BLD_SUMSQ;
  end

  // A reset starts a build of the planes of the reset matrix
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BLD_SUMSQ;
      plane_idx <= '0;
      coef_idx  <= '0;
      cnt       <= '0;
      acc       <= '0;
    end else begin
      state <= state_next;
      if (ctrl.start) begin
        plane_idx <= '0;
        coef_idx  <= '0;
        cnt       <= '0;
        acc       <= '0;
      end else begin
        case (state)
          BLD_SUMSQ: begin
            acc      <= acc_sum;
            coef_idx <= coef_idx + 2'd1;
            if (coef_idx == 2'd2) begin
              cnt <= '0;
            end
          end
          BLD_SQRT: begin
            cnt <= cnt + 6'd1;
            if (cnt == 6'(SQRT_STEPS - 1)) begin
              cnt      <= '0;
              coef_idx <= '0;
            end
          end
          BLD_DIV: begin
            cnt <= cnt + 6'd1;
            if (cnt == 6'(DIV_STEPS - 1)) begin
              cnt      <= '0;
              coef_idx <= coef_idx + 2'd1;
            end
          end
          BLD_NEXT: begin
            plane_idx <= plane_idx + 3'd1;
            coef_idx  <= '0;
            acc       <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      BLD_SUMSQ: begin
        sq_src <= acc_sum;
        sq_rem <= '0;
        root   <= '0;
      end
      BLD_SQRT: begin
        sq_src <= {sq_src[SUMSQ_W-3:0], 2'b00};
        sq_rem <= sq_rem_next;
        root   <= root_next;
        if (cnt == 6'(SQRT_STEPS - 1)) begin
          len    <= root_next;
          dvd    <= {div_abs[MAG_W-1:0], 16'h0000};
          dv_rem <= '0;
          neg    <= div_v[ROWSUM_W-1];
          if (root_next == '0) begin
            planes[plane_idx] <= '{nx: '0, ny: '0, nz: '0, d: COEF_MAX};
          end
        end
      end
      BLD_DIV: begin
        dvd    <= dvd_next;
        dv_rem <= dv_rem_next;
        if (cnt == 6'(DIV_STEPS - 1)) begin
          case (coef_idx)
            2'd0:    planes[plane_idx].nx <= coef;
            2'd1:    planes[plane_idx].ny <= coef;
            2'd2:    planes[plane_idx].nz <= coef;
            default: planes[plane_idx].d  <= coef;
          endcase
          dvd    <= {div_abs[MAG_W-1:0], 16'h0000};
          dv_rem <= '0;
          neg    <= div_v[ROWSUM_W-1];
        end
      end
      default: ;
    endcase
  end

  assign stat.busy = (state != BLD_IDLE);

endmodule

FILE: hw/rtl/fsc_sphere_test.sv
// ----------------------------------------------------------------------------
// fsc_sphere_test
// Three-stage sphere against six planes test with per-stage flow control.
// ----------------------------------------------------------------------------
module fsc_sphere_test (
  input  logic                                       clk,
  input  logic                                       rst,
  input  fsc_pkg::plane_t [fsc_pkg::PLANE_COUNT-1:0] planes,
  input  logic                                       enable,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic signed [fsc_pkg::CTR_W-1:0]           cx_in,
  input  logic signed [fsc_pkg::CTR_W-1:0]           cy_in,
  input  logic signed [fsc_pkg::CTR_W-1:0]           cz_in,
  input  logic [fsc_pkg::RAD_W-1:0]                  r_in,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic                                       visible
);
  import fsc_pkg::*;

  localparam int PROD_W = CTR_W + COEF_W;
  localparam int KT_W   = COEF_W + 9;
  localparam int SUM_W  = PROD_W + 4;

  logic v1, v2;
  logic adv1, adv2, adv3;
  logic signed [CTR_W-1:0] cx, cy, cz;
  logic [RAD_W-1:0]        r;
  logic signed [PROD_W-1:0] px [PLANE_COUNT];
  logic signed [PROD_W-1:0] py [PLANE_COUNT];
  logic signed [PROD_W-1:0] pz [PLANE_COUNT];
  logic signed [KT_W-1:0]   kt [PLANE_COUNT];
  logic                     vis_next;

  assign adv3     = !out_valid || out_ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1 && enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid && in_ready;
      if (adv2) v2 <= v1;
      if (adv3) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      cx <= cx_in;
      cy <= cy_in;
      cz <= cz_in;
      r  <= r_in;
    end
    if (adv2) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        px[p] <= PROD_W'(cx) * PROD_W'(planes[p].nx);
        py[p] <= PROD_W'(cy) * PROD_W'(planes[p].ny);
        pz[p] <= PROD_W'(cz) * PROD_W'(planes[p].nz);
        kt[p] <= (KT_W'(planes[p].d) <<< 8) + signed'(KT_W'({r, 16'h0000}));
      end
    end
    if (adv3) visible <= vis_next;
  end

  always_comb begin
    logic signed [SUM_W-1:0] s;
    vis_next = 1'b1;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      s = SUM_W'(px[p]) + SUM_W'(py[p]) + SUM_W'(pz[p]) + SUM_W'(kt[p]);
      if (s <= 0) vis_next = 1'b0;
    end
  end

endmodule

FILE: test/frustum_sphere_cull_chk.sv
// ----------------------------------------------------------------------------
// frustum_sphere_cull_chk
// Watches the configuration, sphere and result channels. It keeps its own copy
// of the matrix and of the six normalised planes, works out each sphere's flag
// and compares it with the result transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frustum_sphere_cull_chk (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [95:0]                   s_tdata,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [7:0]                    m_tdata,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [fsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fsc_pkg::COL_W-1:0]     cfg_data,
  output int                            fail_count,
  output int                            pending
);
  import fsc_pkg::*;

  logic [COL_W-1:0]         mat_col [REG_COUNT];
  logic signed [COEF_W-1:0] pl_coef [PLANE_COUNT*4];
  bit                       flag_q [$];

  function automatic longint q12_slice(logic [COL_W-1:0] col, int row);
    return longint'($signed(col[16*row +: 16]));
  endfunction

  function automatic longint root_floor(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic logic signed [COEF_W-1:0] clamp32(longint v);
    if (v > longint'(COEF_MAX)) return COEF_MAX;
    if (v < longint'(COEF_MIN)) return COEF_MIN;
    return v[COEF_W-1:0];
  endfunction

  // plane p: row3 - row(p/2) for even p, row3 + row(p/2) for odd p
  task automatic derive_planes();
    longint v [4];
    longint sq, len, sgn;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      sgn = (p % 2 == 1) ? 1 : -1;
      for (int j = 0; j < 4; j++)
        v[j] = q12_slice(mat_col[j], 3) + sgn * q12_slice(mat_col[j], p / 2);
      sq = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
      len = root_floor(sq);
      for (int j = 0; j < 4; j++) begin
        if (len == 0)
          pl_coef[p*4+j] = (j == 3) ? COEF_MAX : '0;  // degenerate plane, never culls
        else
          pl_coef[p*4+j] = clamp32((v[j] * 65536) / len);
      end
    end
  endtask

  function automatic bit sphere_visible(logic [95:0] d);
    longint cx, cy, cz, r, acc;
    cx = longint'($signed(d[23:0]));
    cy = longint'($signed(d[47:24]));
    cz = longint'($signed(d[71:48]));
    r  = longint'(d[94:72]);
    for (int p = 0; p < PLANE_COUNT; p++) begin
      acc = cx * longint'(pl_coef[p*4]) + cy * longint'(pl_coef[p*4+1])
          + cz * longint'(pl_coef[p*4+2]) + longint'(pl_coef[p*4+3]) * 256
          + r * 65536;
      if (acc <= 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      mat_col[0] = 64'd4096;
      mat_col[1] = 64'd4096 << 16;
      mat_col[2] = 64'd4096 << 32;
      mat_col[3] = 64'd4096 << 48;
      derive_planes();
      flag_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (flag_q.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual %0d",
                   $time, m_tdata[0]);
          fail_count++;
        end else if (m_tdata[0] !== flag_q[0]) begin
          $display("%0t: visible mismatch, expected %0d, actual %0d",
                   $time, flag_q[0], m_tdata[0]);
          fail_count++;
          void'(flag_q.pop_front());
        end else begin
          void'(flag_q.pop_front());
        end
      end
      if (s_tvalid && s_tready)
        flag_q.push_back(sphere_visible(s_tdata));
      if (cfg_valid && cfg_ready && cfg_index < REG_COUNT) begin
        mat_col[cfg_index] = cfg_data;
        derive_planes();
      end
    end
    pending = flag_q.size();
  end

endmodule

FILE: test/frustum_sphere_cull_top_tb.sv
// ----------------------------------------------------------------------------
// frustum_sphere_cull_top_tb
// Drives spheres and matrix writes into the culling block over several matrix
// settings with random gaps and back-pressure; the checker scores results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frustum_sphere_cull_top_tb;
  import fsc_pkg::*;

  localparam int PHASES    = 9;
  localparam int PER_PHASE = 112;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [95:0]          s_tdata = '0;   // center_x, center_y, center_z, radius
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;        // visible
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COL_W-1:0]     cfg_data = '0;

  int fail_count, pending;
  bit quiet = 1'b0;      // no idling in the closing phase
  bit hold_req = 1'b0;   // ask the receiver for one long hold-off

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  frustum_sphere_cull_top uut (.*);

  frustum_sphere_cull_chk chk (.*);

  // Overall limit on the run time: each column write starts a plane rebuild
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold so the pipe backs up
  initial begin
    @(negedge rst);
    @(posedge clk);
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (80) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  function automatic logic [95:0] pack_sphere(int cx, int cy, int cz, int r);
    return {1'b0, r[22:0], cz[23:0], cy[23:0], cx[23:0]};
  endfunction

  // Mostly spheres near the origin so both outcomes turn up; some full range
  function automatic logic [95:0] rand_sphere();
    if ($urandom_range(0, 3) != 0)
      return pack_sphere($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                         $urandom_range(0, 4095) - 2048, $urandom_range(0, 1023));
    return {1'b0, 23'($urandom), 24'($urandom), 24'($urandom), 24'($urandom)};
  endfunction

  // One sphere transfer; valid stays high into the next one unless a gap follows
  task automatic send_sphere(logic [95:0] d);
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drain all results before touching the matrix
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_matrix(logic [COL_W-1:0] c0, logic [COL_W-1:0] c1,
                             logic [COL_W-1:0] c2, logic [COL_W-1:0] c3);
    drain();
    write_reg(REG_MATRIX_COL0, c0);
    write_reg(REG_MATRIX_COL1, c1);
    write_reg(REG_MATRIX_COL2, c2);
    write_reg(REG_MATRIX_COL3, c3);
    // unknown index: must leave the matrix alone
    write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, 255)), {$urandom, $urandom});
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        // row 3 equals row 0: the row3-row0 plane has a zero normal
        1: load_matrix(64'h1000_0000_0000_1000, 64'h0000_0000_1000_0000,
                       64'h0000_1000_0000_0000, 64'h0);
        // tiny normal with large offset: d lands just below saturation
        2: load_matrix(64'h0001_0000_0000_0000, 64'h0, 64'h0, 64'h7FFF_0000_0000_0000);
        3: load_matrix(64'h0, 64'h0, 64'h0, 64'h0);
        4: load_matrix('1, '1, '1, '1);
        5: load_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
        6: load_matrix({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
        default: if (ph != 0)
          load_matrix({$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
      endcase
      if (ph == PHASES - 1) quiet = 1'b1;

      if (ph == 0) begin
        // identity planes: x = 1.0 lies on a plane, so it is culled (touch rule)
        send_sphere(pack_sphere(0, 0, 0, 0));
        send_sphere(pack_sphere(256, 0, 0, 0));
        send_sphere(pack_sphere(255, 0, 0, 0));
        send_sphere(pack_sphere(-256, 0, 0, 0));
        send_sphere(pack_sphere(0, 256, 0, 1));
        send_sphere(pack_sphere(0, 0, -257, 1));
        send_sphere(pack_sphere(8388607, 8388607, 8388607, 0));
        send_sphere(pack_sphere(-8388608, -8388608, -8388608, 0));
        send_sphere(pack_sphere(8388607, -8388608, 0, 8388607));
        send_sphere(pack_sphere(-8388608, 8388607, -8388608, 8388607));
        send_sphere(pack_sphere(1024, 0, 0, 768));
        send_sphere(pack_sphere(1024, 0, 0, 767));
        hold_req = 1'b1;
      end else begin
        send_sphere(pack_sphere(0, 0, 0, 0));
        send_sphere(pack_sphere(8388607, -8388608, 8388607, 8388607));
        send_sphere(pack_sphere(-8388608, 8388607, -8388608, 0));
      end
      for (int i = 0; i < PER_PHASE; i++)
        send_sphere(rand_sphere());
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/fsc_pkg.sv
hw/rtl/fsc_plane_builder.sv
hw/rtl/fsc_sphere_test.sv
hw/rtl/frustum_sphere_cull_top.sv
test/frustum_sphere_cull_chk.sv
test/frustum_sphere_cull_top_tb.sv
